@@ rtl/core/sdab_pkg.sv @@
// ----------------------------------------------------------------------------
// sdab_pkg
// Shared types and constants of the segmented detector addback builder.
// ----------------------------------------------------------------------------
`default_nettype none

package sdab_pkg;

  localparam int EW = 20;
  localparam int AW = 24;
  localparam int EVW = 32;
  localparam int SNW = 5;
  localparam int KW = 2;
  localparam int PW = 4;
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  localparam logic [1:0] REG_HIT_THR = 2'd0;
  localparam logic [1:0] REG_VETO_THR = 2'd1;
  localparam logic [1:0] REG_MATCH_TOL = 2'd2;

  localparam logic [KW-1:0] KIND_MAIN = 2'd0;
  localparam logic [KW-1:0] KIND_VETO1 = 2'd1;
  localparam logic [KW-1:0] KIND_VETO2 = 2'd2;

  localparam logic [EW-1:0] HIT_THR_RST = 20'd480;
  localparam logic [EW-1:0] VETO_THR_RST = 20'd1600;
  localparam logic [EW-1:0] MATCH_TOL_RST = 20'd80;

  localparam logic [AW-1:0] ADD_MAX = 24'hFFFFFF;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HIT,
    ST_SCAN,
    ST_MATCH,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ rtl/core/segmented_detector_addback_builder_core.sv @@
// ----------------------------------------------------------------------------
// segmented_detector_addback_builder_core
// Builds events from detector hits and emits one addback word per event.
//
// Input channel (in_*): one hit word per accepted transfer. A hit whose
// event number matches the open event is taken in the hit step. A hit that
// changes the event number, or carries final_hit, closes an event: the
// segment memory is scanned one entry per cycle, then the match and
// emit steps follow and may wait for the output register; a hit that
// both changes the event and is final closes twice.
// Output channel (out_*): a single output register holds the event word
// until the receiver takes it. While it is full and out_stall is high and
// a new event closes, the core holds in its emit step and stalls the input.
// Configuration: APB writes at 0x0, 0x4, 0x8; pready is always high.
// Reset: thresholds return to their defaults, the open event is emptied,
// the current event number becomes zero and the output register is empty.
// No clearing pass is needed; per-entry valid bits empty the memory.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_detector_addback_builder_core
  import sdab_pkg::*;
#(
  parameter int SEGMENTS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,

  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,

  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [EVW-1:0]    event_number,
  input  wire logic [SNW-1:0]    segment_number,
  input  wire logic [KW-1:0]     crystal_kind,
  input  wire logic [EW-1:0]     hit_energy,
  input  wire logic              final_hit,

  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic      [AW-1:0]     addback_energy,
  output logic      [PW-1:0]     peak_segment,
  output logic                   vetoed,
  output logic                   accepted
);

  localparam int IW = $clog2(SEGMENTS);
  localparam int CNTW = $clog2(SEGMENTS + 1);
  localparam int RW = EW + CNTW;
  localparam int CW = (RW > AW) ? RW : AW;
  localparam logic [6:0] SEG_MAX = 7'(SEGMENTS);
  localparam logic [CNTW-1:0] SCAN_END = CNTW'(SEGMENTS);

  // configuration
  logic [EW-1:0] hit_thr;
  logic [EW-1:0] veto_thr;
  logic [EW-1:0] match_tol;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_thr <= HIT_THR_RST;
      veto_thr <= VETO_THR_RST;
      match_tol <= MATCH_TOL_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_HIT_THR:   hit_thr <= pwdata[EW-1:0];
        REG_VETO_THR:  veto_thr <= pwdata[EW-1:0];
        REG_MATCH_TOL: match_tol <= pwdata[EW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_HIT_THR:   prdata = CFG_DW'(hit_thr);
      REG_VETO_THR:  prdata = CFG_DW'(veto_thr);
      REG_MATCH_TOL: prdata = CFG_DW'(match_tol);
      default:       prdata = '0;
    endcase
  end

  // control and event state
  state_t state;
  state_t state_next;

  logic [EVW-1:0] current_event;
  logic [EVW-1:0] ev_q;
  logic [SNW-1:0] seg_q;
  logic [KW-1:0]  kind_q;
  logic [EW-1:0]  energy_q;
  logic           last_q;
  logic           hit_pend;

  logic           first_veto;
  logic           second_veto;
  logic [AW-1:0]  addback;
  logic [SEGMENTS-1:0] seg_valid;

  logic [EW-1:0]  mem [SEGMENTS];
  logic [EW-1:0]  rd_data;
  logic           rd_ok;
  logic           rd_vld;
  logic [IW-1:0]  rd_idx;

  logic [CNTW-1:0] scan_cnt;
  logic [RW-1:0]   run;
  logic [EW-1:0]   peak_e;
  logic [IW-1:0]   peak_idx;
  logic            started;
  logic            run_done;
  logic            match_ok;

  logic           in_acc;
  logic           ev_change;
  logic           mem_we;
  logic           rd_en;
  logic           emit_go;
  logic           seg_ok;
  logic [6:0]     seg_m1;
  logic [AW:0]    add_sum;
  logic [EW-1:0]  e_eff;
  logic [CW-1:0]  run_x;
  logic [CW-1:0]  add_x;
  logic [CW-1:0]  diff;
  logic [AW-1:0]  add_fin;

  assign in_acc = in_valid && !in_stall;
  assign ev_change = event_number != current_event;
  assign seg_m1 = 7'(seg_q) - 7'd1;
  assign seg_ok = (seg_q != '0) && (7'(seg_q) <= SEG_MAX);
  assign add_sum = {1'b0, addback} + (AW + 1)'(energy_q);
  assign e_eff = rd_ok ? rd_data : '0;
  assign run_x = CW'(run);
  assign add_x = CW'(addback);
  assign diff = (run_x > add_x) ? run_x - add_x : add_x - run_x;
  assign add_fin = match_ok ? addback : '0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_acc) state_next = ev_change ? ST_SCAN : ST_HIT;
      ST_HIT:   state_next = last_q ? ST_SCAN : ST_IDLE;
      ST_SCAN:  if (scan_cnt == SCAN_END) state_next = ST_MATCH;
      ST_MATCH: state_next = ST_EMIT;
      ST_EMIT:  if (emit_go) state_next = hit_pend ? ST_HIT : ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    mem_we = 1'b0;
    rd_en = 1'b0;
    emit_go = 1'b0;
    unique case (state)
      ST_IDLE:  in_stall = 1'b0;
      ST_HIT:   mem_we = (kind_q == KIND_MAIN) && (energy_q > hit_thr) && seg_ok &&
                         !(energy_q > veto_thr && (kind_q == KIND_VETO1 ||
                                                   kind_q == KIND_VETO2));
      ST_SCAN:  rd_en = scan_cnt != SCAN_END;
      ST_MATCH: ;
      ST_EMIT:  emit_go = !out_valid || !out_stall;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the hit word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_q <= event_number;
      seg_q <= segment_number;
      kind_q <= crystal_kind;
      energy_q <= hit_energy;
      last_q <= final_hit;
    end
  end

  // segment memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[seg_m1[IW-1:0]] <= energy_q;
    end
    if (rd_en) begin
      rd_data <= mem[scan_cnt[IW-1:0]];
    end
  end

  // event state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_event <= '0;
      hit_pend <= 1'b0;
      first_veto <= 1'b0;
      second_veto <= 1'b0;
      addback <= '0;
      seg_valid <= '0;
    end else begin
      if (in_acc) begin
        hit_pend <= ev_change;
      end
      if (state == ST_HIT) begin
        if (kind_q == KIND_VETO1 && energy_q > veto_thr) begin
          first_veto <= 1'b1;
        end else if (kind_q == KIND_VETO2 && energy_q > veto_thr) begin
          second_veto <= 1'b1;
        end else if (mem_we) begin
          addback <= add_sum[AW] ? ADD_MAX : add_sum[AW-1:0];
          seg_valid[seg_m1[IW-1:0]] <= 1'b1;
        end
      end
      if (emit_go) begin
        first_veto <= 1'b0;
        second_veto <= 1'b0;
        addback <= '0;
        seg_valid <= '0;
        hit_pend <= 1'b0;
        if (hit_pend) begin
          current_event <= ev_q;
        end
      end
    end
  end

  // scan of the first contiguous run
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      scan_cnt <= '0;
    end else begin
      rd_vld <= rd_en;
      if (state != ST_SCAN) begin
        scan_cnt <= '0;
      end else if (rd_en) begin
        scan_cnt <= scan_cnt + CNTW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ok <= seg_valid[scan_cnt[IW-1:0]];
      rd_idx <= scan_cnt[IW-1:0];
    end
    if (state == ST_IDLE || state == ST_HIT) begin
      run <= '0;
      peak_e <= '0;
      peak_idx <= '0;
      started <= 1'b0;
      run_done <= 1'b0;
    end else if (state == ST_SCAN && rd_vld && !run_done) begin
      if (e_eff > hit_thr) begin
        started <= 1'b1;
        run <= run + RW'(e_eff);
        if (e_eff > peak_e) begin
          peak_e <= e_eff;
          peak_idx <= rd_idx;
        end
      end else if (started) begin
        run_done <= 1'b1;
      end
    end
    if (state == ST_MATCH) begin
      match_ok <= diff <= CW'(match_tol);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      addback_energy <= add_fin;
      peak_segment <= PW'(peak_idx);
      vetoed <= first_veto || second_veto;
      accepted <= add_fin > AW'(hit_thr);
    end
  end

  a_rd_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> state == ST_SCAN)
    else $error("segment read data outside scan");

  a_match_after_full_scan: assert property (@(posedge clk) disable iff (rst)
    state == ST_MATCH |-> scan_cnt == SCAN_END && $past(state) == ST_SCAN)
    else $error("match step before scan finished");

  a_clear_on_emit: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> seg_valid == '0 && addback == '0 && out_valid)
    else $error("event not cleared after emit");

  a_hit_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_HIT |=> state == ST_IDLE || state == ST_SCAN)
    else $error("bad step after hit update");

  a_write_then_read: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> !rd_vld)
    else $error("scan read overlaps a segment write");

endmodule

`default_nettype wire
